/* hw/rtl/csmp_pkg.sv */
// Shared types and constants of the chroma subsampler.
package csmp_pkg;

  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned SumW     = 9;   // horizontal pair sum
  localparam int unsigned ChromaW  = 10;  // chroma out, two fraction bits
  localparam int unsigned BufW     = 2 * SumW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_FACTOR_H     = 3'd2,
    CFG_FACTOR_V     = 3'd3,
    CFG_MEAN_MODE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic fh2;
    logic fv2;
    logic mean;
  } mode_t;

  // One pixel between the front stage and the combine stage.
  typedef struct packed {
    logic [7:0]      luma;
    logic [SumW-1:0] hcb;
    logic [SumW-1:0] hcr;
    logic            chroma_valid;
    logic            use_upper;   // block closes on the lower row
    logic            pair_mean;   // horizontal value is a sum of two
    logic            mean;
    logic            eoi;
  } item_t;

endpackage

/* hw/rtl/csmp_line_buf.sv */
// Line buffer holding the reduced upper-row chroma of each column.
module csmp_line_buf #(
  parameter int unsigned DEPTH = csmp_pkg::MaxWidthDef,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [csmp_pkg::BufW-1:0] wdata_i,
  output logic [csmp_pkg::BufW-1:0] rdata_o
);
  import csmp_pkg::*;

  logic [BufW-1:0] mem [DEPTH];
  logic [BufW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

  // A pixel either parks its upper-row value or fetches one, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en_i && rd_en_i))
    else $error("line buffer read and write in the same cycle");

endmodule

/* hw/rtl/csmp_front.sv */
// Front stage: position counters, horizontal pairing, line buffer requests.
module csmp_front #(
  parameter int unsigned MAX_WIDTH  = csmp_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = csmp_pkg::MaxHeightDef,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  csmp_pkg::mode_t           mode_i,
  input  logic [SW-1:0]             w_eff_i,
  input  logic [HW-1:0]             h_eff_i,
  input  logic [7:0]                luma_i,
  input  logic [7:0]                cb_i,
  input  logic [7:0]                cr_i,
  output csmp_pkg::item_t           item_o,
  output logic                      buf_wr_o,
  output logic                      buf_rd_o,
  output logic [CW-1:0]             buf_addr_o,
  output logic [csmp_pkg::BufW-1:0] buf_wdata_o
);
  import csmp_pkg::*;

  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [7:0]      ps_cb_q, ps_cb_d, ps_cr_q, ps_cr_d;
  logic            last_col, last_row, second, h_done, upper, lower;
  logic [SumW-1:0] hcb, hcr;

  assign last_col = (SW'(col_q) + SW'(1)) >= w_eff_i;
  assign last_row = (HW'(row_q) + HW'(1)) >= h_eff_i;
  assign second   = mode_i.fh2 && col_q[0];
  assign h_done   = !mode_i.fh2 || second || last_col;
  assign upper    = mode_i.fv2 && !row_q[0] && !last_row;
  assign lower    = mode_i.fv2 && row_q[0];

  always_comb begin
    if (second) begin
      hcb = mode_i.mean ? ({1'b0, ps_cb_q} + {1'b0, cb_i}) : {1'b0, ps_cb_q};
      hcr = mode_i.mean ? ({1'b0, ps_cr_q} + {1'b0, cr_i}) : {1'b0, ps_cr_q};
    end else begin
      hcb = {1'b0, cb_i};
      hcr = {1'b0, cr_i};
    end
  end

  assign buf_wr_o    = accept_i && h_done && upper;
  assign buf_rd_o    = accept_i && h_done && lower;
  assign buf_addr_o  = col_q;
  assign buf_wdata_o = {hcr, hcb};

  always_comb begin
    item_o.luma         = luma_i;
    item_o.hcb          = hcb;
    item_o.hcr          = hcr;
    item_o.chroma_valid = h_done && !upper;
    item_o.use_upper    = lower;
    item_o.pair_mean    = mode_i.mean && second;
    item_o.mean         = mode_i.mean;
    item_o.eoi          = last_col && last_row;
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    ps_cb_d = ps_cb_q;
    ps_cr_d = ps_cr_q;
    if (accept_i) begin
      if (!second) begin
        ps_cb_d = cb_i;
        ps_cr_d = cr_i;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ps_cb_q <= '0;
      ps_cr_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      ps_cb_q <= ps_cb_d;
      ps_cr_q <= ps_cr_d;
    end
  end

  // With a single-row image every pixel is on the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && h_eff_i == HW'(1)) |=> (row_q == '0))
    else $error("row counter left zero on a one-row image");

endmodule

/* hw/rtl/csmp_combine.sv */
// Combine stage: vertical merge, scaling to two fraction bits, output register.
module csmp_combine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  csmp_pkg::item_t              item_i,
  input  logic [csmp_pkg::BufW-1:0]    rdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   luma_o,
  output logic                         chroma_valid_o,
  output logic [csmp_pkg::ChromaW-1:0] cb_o,
  output logic [csmp_pkg::ChromaW-1:0] cr_o,
  output logic                         eoi_o
);
  import csmp_pkg::*;

  item_t              s1_q;
  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free, s1_adv;
  logic [7:0]         luma_q;
  logic               cv_q, eoi_q;
  logic [ChromaW-1:0] cb_q, cr_q, cb_d, cr_d;
  logic [SumW:0]      tcb, tcr;
  logic [1:0]         sh;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_comb begin
    tcb = {1'b0, s1_q.hcb};
    tcr = {1'b0, s1_q.hcr};
    sh  = s1_q.pair_mean ? 2'd1 : 2'd2;
    if (s1_q.use_upper) begin
      if (s1_q.mean) begin
        tcb = {1'b0, rdata_i[SumW-1:0]} + {1'b0, s1_q.hcb};
        tcr = {1'b0, rdata_i[BufW-1:SumW]} + {1'b0, s1_q.hcr};
        sh  = s1_q.pair_mean ? 2'd0 : 2'd1;
      end else begin
        tcb = {1'b0, rdata_i[SumW-1:0]};
        tcr = {1'b0, rdata_i[BufW-1:SumW]};
        sh  = 2'd2;
      end
    end
    cb_d = s1_q.chroma_valid ? ChromaW'({2'b00, tcb} << sh) : '0;
    cr_d = s1_q.chroma_valid ? ChromaW'({2'b00, tcr} << sh) : '0;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      luma_q <= s1_q.luma;
      cv_q   <= s1_q.chroma_valid;
      eoi_q  <= s1_q.eoi;
      cb_q   <= cb_d;
      cr_q   <= cr_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign luma_o         = luma_q;
  assign chroma_valid_o = cv_q;
  assign cb_o           = cb_q;
  assign cr_o           = cr_q;
  assign eoi_o          = eoi_q;

endmodule

/* hw/rtl/chroma_subsampler_mean_or_point_unit.sv */
// Top level of the chroma subsampler: config registers and stage wiring.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata: luma, cb, cr
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata: luma, cb, cr; tuser; tlast
//  cfg      in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One beat per clock in and out while m_axis is not stalled. The input beat's
// edge loads the combine stage and issues the line buffer read; the pixel then
// moves into the output register once that is free, and leaves from there.
// The line buffer has one port; a pixel writes or reads it in its input cycle.
// Reset clears counters and pair registers, presets config; the buffer needs no pass.
// A stall on m_axis holds the output register; input keeps flowing until
// the combine stage is also full, then s_axis_tready drops.
module chroma_subsampler_mean_or_point_unit #(
  parameter int unsigned MAX_WIDTH  = csmp_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = csmp_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // luma_in, cb_in, cr_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // luma_out, cb_out, cr_out, zero pad
  output logic                          m_axis_tuser,  // chroma_valid
  output logic                          m_axis_tlast,  // end_of_image
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [csmp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csmp_pkg::CfgDataW-1:0] cfg_data_i
);
  import csmp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  // config registers
  logic [CfgDataW-1:0] width_q, height_q;
  logic [1:0]          fh_q, fv_q;
  logic                mean_q;
  logic [SW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  mode_t               mode;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDataW'(1);
      height_q <= CfgDataW'(1);
      fh_q     <= 2'd2;
      fv_q     <= 2'd2;
      mean_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_FACTOR_H:     fh_q     <= cfg_data_i[1:0];
        CFG_FACTOR_V:     fv_q     <= cfg_data_i[1:0];
        CFG_MEAN_MODE:    mean_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign mode.fh2  = (fh_q == 2'd2);
  assign mode.fv2  = (fv_q == 2'd2);
  assign mode.mean = mean_q;

  logic               in_accept;
  item_t              item;
  logic               buf_wr, buf_rd;
  logic [CW-1:0]      buf_addr;
  logic [BufW-1:0]    buf_wdata, buf_rdata;
  logic [7:0]         luma_out;
  logic [ChromaW-1:0] cb_out, cr_out;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  csmp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .mode_i      (mode),
    .w_eff_i     (w_eff),
    .h_eff_i     (h_eff),
    .luma_i      (s_axis_tdata[7:0]),
    .cb_i        (s_axis_tdata[15:8]),
    .cr_i        (s_axis_tdata[23:16]),
    .item_o      (item),
    .buf_wr_o    (buf_wr),
    .buf_rd_o    (buf_rd),
    .buf_addr_o  (buf_addr),
    .buf_wdata_o (buf_wdata)
  );

  // Upper-row write and lower-row read of a column are at least one
  // pixel apart, so the read always sees the completed write.
  csmp_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (buf_wr),
    .rd_en_i (buf_rd),
    .addr_i  (buf_addr),
    .wdata_i (buf_wdata),
    .rdata_o (buf_rdata)
  );

  csmp_combine u_combine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .item_i         (item),
    .rdata_i        (buf_rdata),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .luma_o         (luma_out),
    .chroma_valid_o (m_axis_tuser),
    .cb_o           (cb_out),
    .cr_o           (cr_out),
    .eoi_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, cr_out, cb_out, luma_out};

  // The last pixel of an image always lies on the last row, so it closes a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("end of image without chroma");

  // Chroma fields are zero when no block closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[27:8] == '0))
    else $error("chroma data without chroma_valid");

endmodule

/* bench/csmp_output_checker.sv */
// Checker for the chroma subsampler: predicts every output beat and compares it.
module csmp_output_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pix_valid_i,
  input  logic                          pix_ready_i,
  input  logic [23:0]                   pix_data_i,   // luma, cb, cr
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [31:0]                   out_data_i,   // luma, cb_out, cr_out, zero pad
  input  logic                          out_user_i,   // chroma_valid
  input  logic                          out_last_i,   // end_of_image
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [csmp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csmp_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            mismatch_count_o,
  output int                            pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import csmp_pkg::*;

  typedef struct packed {
    logic [7:0]         luma;
    logic               chroma_valid;
    logic [ChromaW-1:0] cb;
    logic [ChromaW-1:0] cr;
    logic               eoi;
  } pixel_out_t;

  // configuration copy
  logic [CfgDataW-1:0] width_q, height_q;
  logic [1:0]          factor_h_q, factor_v_q;
  logic                mean_q;

  // position and horizontal pair
  logic [11:0]         col_q, row_q;
  logic [SumW-1:0]     pair_cb_q, pair_cr_q;
  bit   [BufW-1:0]     upper_sums [MaxWidthDef];

  pixel_out_t          expected_pixels_q [$];
  pixel_out_t          want, got;
  int                  mismatches;
  int                  beat_no;

  function automatic logic [12:0] clamp_size(input logic [CfgDataW-1:0] v, input int unsigned lim);
    if (v == '0) return 13'd1;
    if (v > lim) return lim[12:0];
    return v;
  endfunction

  function automatic pixel_out_t subsample_pixel(input logic [7:0] y, cb, cr);
    logic [12:0]        w, h;
    logic               fh2, fv2, mean, last_col, last_row, second, h_done;
    logic [SumW-1:0]    hcb, hcr, ucb, ucr;
    logic [ChromaW-1:0] tcb, tcr;
    logic [ChromaW+1:0] scb, scr;
    int unsigned        hcount, count, shift;
    pixel_out_t         res;
    w        = clamp_size(width_q, MaxWidthDef);
    h        = clamp_size(height_q, MaxHeightDef);
    fh2      = (factor_h_q == 2'd2);
    fv2      = (factor_v_q == 2'd2);
    mean     = mean_q;
    last_col = ({1'b0, col_q} + 13'd1) >= w;
    last_row = ({1'b0, row_q} + 13'd1) >= h;
    second   = fh2 && col_q[0];
    h_done   = !fh2 || second || last_col;
    tcb      = '0;
    tcr      = '0;
    count    = 1;
    res      = '0;

    if (second) begin
      hcb = mean ? pair_cb_q + cb : pair_cb_q;
      hcr = mean ? pair_cr_q + cr : pair_cr_q;
    end else begin
      hcb       = {1'b0, cb};
      hcr       = {1'b0, cr};
      pair_cb_q = {1'b0, cb};
      pair_cr_q = {1'b0, cr};
    end
    hcount = (mean && second) ? 2 : 1;

    if (h_done) begin
      if (fv2 && !row_q[0] && !last_row) begin
        // upper row of a block: park the horizontal value
        upper_sums[col_q] = {hcr, hcb};
      end else if (fv2 && row_q[0]) begin
        ucb = upper_sums[col_q][SumW-1:0];
        ucr = upper_sums[col_q][BufW-1:SumW];
        if (mean) begin
          tcb   = ucb + hcb;
          tcr   = ucr + hcr;
          count = hcount * 2;
        end else begin
          tcb   = ucb;
          tcr   = ucr;
          count = 1;
        end
        res.chroma_valid = 1'b1;
      end else begin
        tcb              = hcb;
        tcr              = hcr;
        count            = hcount;
        res.chroma_valid = 1'b1;
      end
    end

    // scale to value*4
    shift  = (count == 4) ? 0 : (count == 2) ? 1 : 2;
    scb    = {2'b00, tcb} << shift;
    scr    = {2'b00, tcr} << shift;
    res.cb = scb[ChromaW-1:0];
    res.cr = scr[ChromaW-1:0];
    res.luma = y;
    res.eoi  = last_col && last_row;

    if (last_col) begin
      col_q = '0;
      row_q = last_row ? '0 : row_q + 12'd1;
    end else begin
      col_q = col_q + 12'd1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] beat %0d: %s", $realtime, beat_no, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    = 13'd1;
      height_q   = 13'd1;
      factor_h_q = 2'd2;
      factor_v_q = 2'd2;
      mean_q     = 1'b1;
      col_q      = '0;
      row_q      = '0;
      pair_cb_q  = '0;
      pair_cr_q  = '0;
      expected_pixels_q.delete();
      mismatches = 0;
      beat_no    = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:  width_q    = cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q   = cfg_data_i;
          CFG_FACTOR_H:     factor_h_q = cfg_data_i[1:0];
          CFG_FACTOR_V:     factor_v_q = cfg_data_i[1:0];
          CFG_MEAN_MODE:    mean_q     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) begin
        expected_pixels_q.push_back(
          subsample_pixel(pix_data_i[7:0], pix_data_i[15:8], pix_data_i[23:16]));
      end
      if (out_valid_i && out_ready_i) begin
        got.luma         = out_data_i[7:0];
        got.chroma_valid = out_user_i;
        got.cb           = out_data_i[17:8];
        got.cr           = out_data_i[27:18];
        got.eoi          = out_last_i;
        if (expected_pixels_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat y=%0h v=%0b cb=%0h cr=%0h eoi=%0b",
                                    got.luma, got.chroma_valid, got.cb, got.cr, got.eoi));
        end else begin
          want = expected_pixels_q.pop_front();
          if (got != want || out_data_i[31:28] != 4'h0) begin
            report_mismatch({
              $sformatf("exp y=%0h v=%0b cb=%0h cr=%0h eoi=%0b pad=0",
                        want.luma, want.chroma_valid, want.cb, want.cr, want.eoi),
              $sformatf(" / got y=%0h v=%0b cb=%0h cr=%0h eoi=%0b pad=%0h",
                        got.luma, got.chroma_valid, got.cb, got.cr, got.eoi,
                        out_data_i[31:28])});
          end
        end
        beat_no++;
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_pixels_q.size();
    end
  end

endmodule

/* bench/chroma_subsampler_mean_or_point_unit_tb.sv */
// Top of the chroma subsampler bench: stimulus, output back-pressure and verdict.
module chroma_subsampler_mean_or_point_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csmp_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // luma_in, cb_in, cr_in
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;   // luma_out, cb_out, cr_out, zero pad
  logic                m_axis_tuser;   // chroma_valid
  logic                m_axis_tlast;   // end_of_image
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int mismatch_count;
  int pending_count;

  // zero-gap stretch counters, one per side
  int in_burst_left  = 0;
  int out_burst_left = 0;

  chroma_subsampler_mean_or_point_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  csmp_output_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix_valid_i      (s_axis_tvalid),
    .pix_ready_i      (s_axis_tready),
    .pix_data_i       (s_axis_tdata),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_user_i       (m_axis_tuser),
    .out_last_i       (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: a run that has not finished by then is reported as failed.
  initial begin
    #3_000_000;
    $display("** chroma_subsampler_mean_or_point_unit: FAILED **");
    $finish;
  end

  // Idle cycles before a beat are drawn at random, with occasional zero-gap stretches.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Output side: stall m_axis_tready a random number of cycles per beat.
  initial begin : out_side
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(out_burst_left);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      // values read right after the edge are the ones the edge sampled
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One pixel beat. tvalid stays high across back-to-back beats.
  task automatic send_pixel(input logic [7:0] y, cb, cr);
    int gap;
    gap = draw_wait(in_burst_left);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cr, cb, y};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every predicted beat is out, then let the pipeline settle.
  task automatic wait_drain();
    do @(posedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Program all registers, stream whole images, drain. Register writes only
  // happen between images, so the line buffer is never read unwritten.
  task automatic stream_images(input logic [12:0] w, h, input logic [1:0] fh, fv,
                               input logic mean, input int images, input bit all_max,
                               output int sent);
    int eff_w, eff_h;
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_FACTOR_H, {11'd0, fh});
    write_reg(CFG_FACTOR_V, {11'd0, fv});
    write_reg(CFG_MEAN_MODE, {12'd0, mean});
    // 0 reads as 1, oversize saturates at the maximum
    eff_w = (w == 0) ? 1 : (w > MaxWidthDef) ? MaxWidthDef : w;
    eff_h = (h == 0) ? 1 : (h > MaxHeightDef) ? MaxHeightDef : h;
    sent  = 0;
    for (int n = 0; n < images * eff_w * eff_h; n++) begin
      if (all_max) send_pixel(8'hFF, 8'hFF, 8'hFF);
      else send_random_pixel();
      sent++;
    end
    s_axis_tvalid <= 1'b0;
    wait_drain();
  endtask

  initial begin : stimulus
    int sent, random_pixels;
    logic [12:0] w, h;
    logic [1:0]  fh, fv;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_IMAGE_WIDTH;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reset settings: 1x1 image, 2x2 mean; a single pixel is its own corner
    send_pixel(8'h00, 8'h00, 8'h00);
    s_axis_tvalid <= 1'b0;
    wait_drain();
    // 3x3 mean at full scale: full block, odd column, odd row, odd corner
    stream_images(13'd3, 13'd3, 2'd2, 2'd2, 1'b1, 1, 1'b1, sent);
    // same shape in point mode
    stream_images(13'd3, 13'd3, 2'd2, 2'd2, 1'b0, 1, 1'b0, sent);
    // even 2x2 mean block
    stream_images(13'd2, 13'd2, 2'd2, 2'd2, 1'b1, 1, 1'b0, sent);

    // --- extremes ---
    // oversize width and height saturate, so a short run never wraps; then a
    // one-pixel width ends the row at the current column and a one-row height
    // ends the image there. Vertical factor 1 keeps the line buffer out of it.
    write_reg(CFG_IMAGE_WIDTH, 13'd4097);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(CFG_FACTOR_H, 13'd2);
    write_reg(CFG_FACTOR_V, 13'd1);
    write_reg(CFG_MEAN_MODE, 13'd1);
    for (int n = 0; n < 24; n++) begin
      send_random_pixel();
    end
    s_axis_tvalid <= 1'b0;
    wait_drain();
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    write_reg(CFG_IMAGE_HEIGHT, 13'd1);
    send_random_pixel();
    s_axis_tvalid <= 1'b0;
    wait_drain();
    // zero width reads as 1, factor code 3 is 1
    stream_images(13'd0, 13'd3, 2'd3, 2'd2, 1'b0, 1, 1'b0, sent);

    // --- random settings, small images ---
    random_pixels = 0;
    while (random_pixels < 380) begin
      w  = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(1, 12));
      h  = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
      // mostly legal factors, sometimes the codes that fall back to 1
      fh = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 2'd3 : 2'd0)
                                       : 2'($urandom_range(1, 2));
      fv = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 2'd3 : 2'd0)
                                       : 2'($urandom_range(1, 2));
      stream_images(w, h, fh, fv, 1'($urandom_range(0, 1)), $urandom_range(1, 3), 1'b0,
                    sent);
      random_pixels += sent;
    end

    wait_drain();
    if (mismatch_count == 0) begin
      $display("** chroma_subsampler_mean_or_point_unit: PASSED **");
    end else begin
      $display("** chroma_subsampler_mean_or_point_unit: FAILED **");
    end
    $finish;
  end

endmodule
